// ===== rtl/multi_train_speed_reverse_sequencer_top_defines.svh =====
// Assertion macros shared by the sequencer. Each expects clk and rst in scope.
`ifndef MULTI_TRAIN_SPEED_REVERSE_SEQUENCER_TOP_DEFINES_SVH
`define MULTI_TRAIN_SPEED_REVERSE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTSRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTSRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mtsrs_pkg.sv =====
`timescale 1ns / 1ps

package mtsrs_pkg;

  localparam int NUM_TRAINS_DEF = 16;

  localparam int FUNC_W      = 2;
  localparam int TRAIN_NUM_W = 8;
  localparam int STEP_W      = 8;
  localparam int KIND_W      = 2;
  localparam int TRAIN_W     = 5;
  localparam int VALUE_W     = 10;
  localparam int SPEED_W     = 4;
  localparam int CD_W        = 11;
  localparam int BASE_W      = 10;
  localparam int RATE_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int CNT_W       = 6;

  localparam int MAX_STEP    = 14;
  localparam int STEP_SCALE  = 77;
  localparam int MAX_RESULTS = 32;

  localparam logic [FUNC_W-1:0] FUNC_SPEED   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REVERSE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FUNC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPEED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 1'd1;

  localparam logic [BASE_W-1:0] BASE_RESET = 10'd50;
  localparam logic [RATE_W-1:0] RATE_RESET = 6'd25;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               forward;
    logic               reversing;
    logic               touched;
    logic [CD_W-1:0]    countdown;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    speed:     '0,
    forward:   1'b1,
    reversing: 1'b0,
    touched:   1'b0,
    countdown: '0
  };

  // Track speed for a step: zero stays zero, otherwise 1 + (step - 1) * scale.
  function automatic logic [VALUE_W-1:0] scaled_speed(input logic [SPEED_W-1:0] step);
    logic [VALUE_W:0] s;
    s = (VALUE_W+1)'(1) + (VALUE_W+1)'(step - SPEED_W'(1)) * (VALUE_W+1)'(STEP_SCALE);
    return (step == '0) ? '0 : s[VALUE_W-1:0];
  endfunction

endpackage

// ===== rtl/mtsrs_store.sv =====
`timescale 1ns / 1ps

module mtsrs_store #(
  parameter int NUM_TRAINS = mtsrs_pkg::NUM_TRAINS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              rd_en,
  input  logic [((NUM_TRAINS > 1) ? $clog2(NUM_TRAINS) : 1)-1:0] rd_addr,
  output mtsrs_pkg::entry_t                                 rd_data,
  input  logic                                              wr_en,
  input  logic [((NUM_TRAINS > 1) ? $clog2(NUM_TRAINS) : 1)-1:0] wr_addr,
  input  mtsrs_pkg::entry_t                                 wr_data
);

  mtsrs_pkg::entry_t mem [NUM_TRAINS];
  logic [NUM_TRAINS-1:0] vld;
  mtsrs_pkg::entry_t rd_raw;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads back as the reset entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : mtsrs_pkg::ENTRY_RESET;

endmodule

// ===== rtl/multi_train_speed_reverse_sequencer_top.sv =====
`timescale 1ns / 1ps
// Channel        Handshake             Payload
// request in     start / busy          func, train_number, speed_step
// command out    strobe (no back-off)  cmd_kind, cmd_train, cmd_value, last
// config write   cfg_write             cfg_index, cfg_data
//
// A speed or reverse request passes the entry, any emit and the flush state before busy falls.
// A tick walks the train table one entry per cycle through its read and write ports,
// except where an expiring train holds the walk to send its direction and speed commands.
// Invalid requests are accepted and dropped without raising busy.
// Reset is synchronous; per-entry valid bits make the table read as reset at once.
// Commands appear one cycle each on strobe and cannot be held off by the receiver.

`include "multi_train_speed_reverse_sequencer_top_defines.svh"

module multi_train_speed_reverse_sequencer_top #(
  parameter int NUM_TRAINS = mtsrs_pkg::NUM_TRAINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mtsrs_pkg::FUNC_W-1:0]        func,
  input  logic [mtsrs_pkg::TRAIN_NUM_W-1:0]   train_number,
  input  logic [mtsrs_pkg::STEP_W-1:0]        speed_step,
  output logic                                strobe,
  output logic [mtsrs_pkg::KIND_W-1:0]        cmd_kind,
  output logic [mtsrs_pkg::TRAIN_W-1:0]       cmd_train,
  output logic [mtsrs_pkg::VALUE_W-1:0]       cmd_value,
  output logic                                last,
  input  logic                                cfg_write,
  input  logic [mtsrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtsrs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = (NUM_TRAINS > 1) ? $clog2(NUM_TRAINS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TRAINS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ENT   = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam int M_F0    = 0;
  localparam int M_DIR   = 1;
  localparam int M_SPEED = 2;

  logic [1:0] state;

  logic [mtsrs_pkg::BASE_W-1:0] base;
  logic [mtsrs_pkg::RATE_W-1:0] rate;

  // Request held for the duration of its work.
  logic                            is_tick;
  logic                            is_reverse;
  logic [mtsrs_pkg::SPEED_W-1:0]   op_step;
  logic [mtsrs_pkg::TRAIN_W-1:0]   op_train;
  logic [IDX_W-1:0]                idx;
  logic [mtsrs_pkg::CNT_W-1:0]     n;

  // Commands still to be sent for the current train.
  logic [2:0]                      mask;
  logic [mtsrs_pkg::TRAIN_W-1:0]   q_train;
  logic                            q_dir;
  logic [mtsrs_pkg::VALUE_W-1:0]   q_speed;

  // One command is held back so that the final one can be marked.
  logic                            pend_valid;
  logic [mtsrs_pkg::KIND_W-1:0]    pend_kind;
  logic [mtsrs_pkg::TRAIN_W-1:0]   pend_train;
  logic [mtsrs_pkg::VALUE_W-1:0]   pend_value;

  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  mtsrs_pkg::entry_t               e;
  mtsrs_pkg::entry_t               e_new;
  logic                            wr_en;

  logic                            accept;
  logic                            train_ok;
  logic                            cmd_ok;
  logic                            tick_go;

  logic [2:0]                      m;
  logic                            dirv;
  logic [mtsrs_pkg::VALUE_W-1:0]   speedv;
  logic [mtsrs_pkg::CD_W-1:0]      c;
  logic [mtsrs_pkg::BASE_W-1:0]    prod;
  logic [mtsrs_pkg::TRAIN_W-1:0]   cur_train;
  logic [5:0]                      train_inc;

  logic [2:0]                      mask_rest;
  logic [mtsrs_pkg::KIND_W-1:0]    new_kind;
  logic [mtsrs_pkg::VALUE_W-1:0]   new_value;
  logic                            tail;
  logic                            more;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign train_ok = (train_number != '0) &&
                    ({1'b0, train_number} <= (mtsrs_pkg::TRAIN_NUM_W+1)'(NUM_TRAINS));
  assign tick_go  = (func == mtsrs_pkg::FUNC_TICK);
  assign cmd_ok   = train_ok &&
                    (((func == mtsrs_pkg::FUNC_SPEED) &&
                      (speed_step <= mtsrs_pkg::STEP_W'(mtsrs_pkg::MAX_STEP))) ||
                     (func == mtsrs_pkg::FUNC_REVERSE));

  assign train_inc = 6'(idx) + 6'd1;
  assign cur_train = is_tick ? train_inc[mtsrs_pkg::TRAIN_W-1:0] : op_train;
  assign prod      = mtsrs_pkg::BASE_W'(e.speed) * mtsrs_pkg::BASE_W'(rate);

  // Read-modify-write of the entry that arrived from the table this cycle.
  always_comb begin
    e_new  = e;
    m      = '0;
    dirv   = 1'b0;
    speedv = '0;
    c      = (e.countdown <= mtsrs_pkg::CD_W'(1)) ? '0 : e.countdown - mtsrs_pkg::CD_W'(1);
    if (is_tick) begin
      if (e.reversing) begin
        if (c == '0) begin
          if (n > mtsrs_pkg::CNT_W'(mtsrs_pkg::MAX_RESULTS - 2)) begin
            // No room left in this tick; the train expires on a later one.
            e_new.countdown = mtsrs_pkg::CD_W'(1);
          end else begin
            m[M_DIR]        = 1'b1;
            m[M_SPEED]      = 1'b1;
            dirv            = e.forward;
            speedv          = mtsrs_pkg::scaled_speed(e.speed);
            e_new.forward   = !e.forward;
            e_new.reversing = 1'b0;
            e_new.countdown = '0;
          end
        end else begin
          e_new.countdown = c;
        end
      end
    end else begin
      if (!e.touched) begin
        m[M_F0]       = 1'b1;
        m[M_DIR]      = 1'b1;
        e_new.touched = 1'b1;
      end
      m[M_SPEED] = 1'b1;
      if (!is_reverse) begin
        e_new.speed = op_step;
        m[M_SPEED]  = !e.reversing;
        speedv      = mtsrs_pkg::scaled_speed(op_step);
      end else if (e.reversing) begin
        e_new.reversing = 1'b0;
        speedv          = mtsrs_pkg::scaled_speed(e.speed);
      end else begin
        e_new.reversing = 1'b1;
        e_new.countdown = mtsrs_pkg::CD_W'(base) + mtsrs_pkg::CD_W'(prod);
      end
    end
  end

  assign mask_rest = mask & (mask - 3'd1);

  always_comb begin
    if (mask[M_F0]) begin
      new_kind  = mtsrs_pkg::KIND_FUNC;
      new_value = mtsrs_pkg::VALUE_W'(1);
    end else if (mask[M_DIR]) begin
      new_kind  = mtsrs_pkg::KIND_DIR;
      new_value = mtsrs_pkg::VALUE_W'(q_dir);
    end else begin
      new_kind  = mtsrs_pkg::KIND_SPEED;
      new_value = q_speed;
    end
  end

  assign tail  = ((state == S_ENT) && (m == '0)) || ((state == S_EMIT) && (mask_rest == '0));
  assign more  = tail && is_tick && (idx != LAST_IDX);
  assign wr_en = (state == S_ENT);

  always_comb begin
    rd_en   = more || (accept && (tick_go || cmd_ok));
    rd_addr = IDX_W'(train_number - mtsrs_pkg::TRAIN_NUM_W'(1));
    if (more) begin
      rd_addr = idx + IDX_W'(1);
    end else if (tick_go) begin
      rd_addr = '0;
    end
  end

  mtsrs_store #(
    .NUM_TRAINS(NUM_TRAINS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (e),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (e_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base       <= mtsrs_pkg::BASE_RESET;
      rate       <= mtsrs_pkg::RATE_RESET;
      mask       <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          mtsrs_pkg::REG_BASE: base <= cfg_data[mtsrs_pkg::BASE_W-1:0];
          mtsrs_pkg::REG_RATE: rate <= cfg_data[mtsrs_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (tick_go || cmd_ok)) begin
            state <= S_ENT;
            n     <= '0;
          end
        end
        S_ENT: begin
          if (m != '0) begin
            state <= S_EMIT;
            mask  <= m;
            if (is_tick) begin
              n <= n + mtsrs_pkg::CNT_W'(2);
            end
          end else if (!more) begin
            state <= S_FLUSH;
          end
        end
        S_EMIT: begin
          strobe     <= pend_valid;
          pend_valid <= 1'b1;
          mask       <= mask_rest;
          if (mask_rest == '0) begin
            state <= more ? S_ENT : S_FLUSH;
          end
        end
        S_FLUSH: begin
          strobe     <= pend_valid;
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick    <= tick_go;
      is_reverse <= (func == mtsrs_pkg::FUNC_REVERSE);
      op_step    <= speed_step[mtsrs_pkg::SPEED_W-1:0];
      op_train   <= train_number[mtsrs_pkg::TRAIN_W-1:0];
      idx        <= rd_addr;
    end else if (more) begin
      idx <= rd_addr;
    end
    if (state == S_ENT) begin
      q_train <= cur_train;
      q_dir   <= dirv;
      q_speed <= speedv;
    end
    if (state == S_EMIT) begin
      cmd_kind   <= pend_kind;
      cmd_train  <= pend_train;
      cmd_value  <= pend_value;
      last       <= 1'b0;
      pend_kind  <= new_kind;
      pend_train <= q_train;
      pend_value <= new_value;
    end else if (state == S_FLUSH) begin
      cmd_kind  <= pend_kind;
      cmd_train <= pend_train;
      cmd_value <= pend_value;
      last      <= 1'b1;
    end
  end

  `MTSRS_ASSERT_NOW(a_strobe_from_busy, strobe, $past(busy), "command sent without a request")
  `MTSRS_ASSERT_NEXT(a_last_ends_burst, strobe && last, !strobe, "command after final one")
  `MTSRS_ASSERT_NOW(a_idle_no_pending, state == S_IDLE, !pend_valid, "command left behind")

endmodule
